/* sv/indexed_max_heap_assert.svh */
// Assertion macros for the indexed max-heap checker.
`ifndef INDEXED_MAX_HEAP_ASSERT_SVH
`define INDEXED_MAX_HEAP_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define IMH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IMH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* sv/imh_pkg.sv */
// Shared types and constants of the indexed max-heap.
package imh_pkg;

    localparam int HEAP_DEPTH = 256;
    localparam int KEY_SPACE  = 1024;
    localparam int VALUE_BITS = 32;

    localparam int KEY_W = $clog2(KEY_SPACE);
    localparam int POS_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int CHD_W = POS_W + 2;

    localparam logic [VALUE_BITS-1:0] INT_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_POP    = 2'd2,
        CMD_LOOKUP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // One heap slot: key and signed value.
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] val;
    } slot_t;

    // One position table entry.
    typedef struct packed {
        logic             present;
        logic [POS_W-1:0] pos;
    } pent_t;

    localparam int SLOT_W = $bits(slot_t);
    localparam int PENT_W = $bits(pent_t);

endpackage

/* sv/imh_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module imh_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/indexed_max_heap.sv */
// Indexed max-heap: insert, remove by key, pop maximum and lookup by key.
//
// Input channel s_*: one command word (command, key, value) per handshake.
// Result channel m_*: exactly one result word per command, in order, giving
// status, looked-up value, the maximum pair and the entry count afterwards.
// Commands are processed one at a time. Insert, remove and pop take longer
// the more levels they sift up or down, since each level reads the heap
// slot RAM through its single read port.
// A result sits in an output register, so the next command is accepted
// while it waits; that command stalls in its last step until the result
// register is free.
// After reset all 1024 key position table entries are cleared, one entry
// a cycle, during which s_ready stays low.
module indexed_max_heap
    import imh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic [KEY_W-1:0]      s_key,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [VALUE_BITS-1:0] m_found_value,
    output logic                  m_top_valid,
    output logic [KEY_W-1:0]      m_top_key,
    output logic [VALUE_BITS-1:0] m_top_value,
    output logic [CNT_W-1:0]      m_entry_count
);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_LKP   = 14'b00000000000100,
        S_POPRD = 14'b00000000001000,
        S_REM   = 14'b00000000010000,
        S_LAST  = 14'b00000000100000,
        S_LKV   = 14'b00000001000000,
        S_UP    = 14'b00000010000000,
        S_UPC   = 14'b00000100000000,
        S_DNA   = 14'b00001000000000,
        S_DNB   = 14'b00010000000000,
        S_DNC   = 14'b00100000000000,
        S_PLACE = 14'b01000000000000,
        S_TOP   = 14'b10000000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [KEY_W-1:0]      clr_reg, clr_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    slot_t                 mov_reg, mov_next;
    slot_t                 c1d_reg, c1d_next;
    status_t               status_reg, status_next;
    logic [VALUE_BITS-1:0] found_reg, found_next;
    logic                  topr_reg, topr_next;

    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_status_reg, m_status_next;
    logic [VALUE_BITS-1:0] m_found_reg, m_found_next;
    logic                  m_tv_reg, m_tv_next;
    logic [KEY_W-1:0]      m_tk_reg, m_tk_next;
    logic [VALUE_BITS-1:0] m_tval_reg, m_tval_next;
    logic [CNT_W-1:0]      m_cnt_reg, m_cnt_next;

    // heap slot RAM
    logic             h_we, h_re;
    logic [POS_W-1:0] h_waddr, h_raddr;
    slot_t            h_wdata, h_rdata;
    // position table RAM
    logic             p_we, p_re;
    logic [KEY_W-1:0] p_waddr, p_raddr;
    pent_t            p_wdata, p_rdata;

    imh_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(SLOT_W)) u_heap (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    imh_ram #(.DEPTH(KEY_SPACE), .WIDTH(PENT_W)) u_pos (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // index arithmetic
    logic [CHD_W-1:0] c1_idx, c2_idx;
    logic [POS_W-1:0] par_idx;
    logic [CNT_W-1:0] fill_dec;
    logic             out_free;
    slot_t            best;
    logic [CHD_W-1:0] best_idx;

    assign c1_idx   = {1'b0, pos_reg, 1'b1};
    assign c2_idx   = c1_idx + CHD_W'(1);
    assign par_idx  = POS_W'((pos_reg - POS_W'(1)) >> 1);
    assign fill_dec = fill_reg - CNT_W'(1);
    assign out_free = !m_valid_reg || m_ready;

    // larger child, left preferred on a tie
    always_comb begin
        if (state_reg == S_DNC && $signed(c1d_reg.val) < $signed(h_rdata.val)) begin
            best     = h_rdata;
            best_idx = c2_idx;
        end else if (state_reg == S_DNC) begin
            best     = c1d_reg;
            best_idx = c1_idx;
        end else begin
            best     = h_rdata;
            best_idx = c1_idx;
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        fill_next     = fill_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        pos_next      = pos_reg;
        mov_next      = mov_reg;
        c1d_next      = c1d_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        topr_next     = 1'b0;
        h_we          = 1'b0;
        h_waddr       = pos_reg;
        h_wdata       = mov_reg;
        h_re          = 1'b0;
        h_raddr       = '0;
        p_we          = 1'b0;
        p_waddr       = mov_reg.key;
        p_wdata       = '{present: 1'b1, pos: pos_reg};
        p_re          = 1'b0;
        p_raddr       = s_key;

        unique case (state_reg)
            S_CLEAR: begin
                p_we     = 1'b1;
                p_waddr  = clr_reg;
                p_wdata  = '0;
                clr_next = clr_reg + KEY_W'(1);
                if (clr_reg == KEY_W'(KEY_SPACE - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next    = cmd_t'(s_command);
                    key_next    = s_key;
                    val_next    = s_value;
                    status_next = ST_OK;
                    found_next  = '0;
                    if (cmd_t'(s_command) == CMD_POP) begin
                        if (fill_reg == '0) begin
                            status_next = ST_ABSENT;
                            state_next  = S_TOP;
                        end else begin
                            h_re       = 1'b1;
                            state_next = S_POPRD;
                        end
                    end else begin
                        p_re       = 1'b1;
                        state_next = S_LKP;
                    end
                end
            end
            S_LKP: begin
                unique case (cmd_reg)
                    CMD_INSERT: begin
                        mov_next = '{key: key_reg, val: val_reg};
                        if (p_rdata.present) begin
                            pos_next   = p_rdata.pos;
                            state_next = S_UP;
                        end else if (fill_reg == CNT_W'(HEAP_DEPTH)) begin
                            status_next = ST_FULL;
                            state_next  = S_TOP;
                        end else begin
                            pos_next   = POS_W'(fill_reg);
                            fill_next  = fill_reg + CNT_W'(1);
                            state_next = S_UP;
                        end
                    end
                    CMD_REMOVE: begin
                        if (p_rdata.present) begin
                            pos_next   = p_rdata.pos;
                            state_next = S_REM;
                        end else begin
                            status_next = ST_ABSENT;
                            state_next  = S_TOP;
                        end
                    end
                    default: begin
                        if (p_rdata.present) begin
                            h_re       = 1'b1;
                            h_raddr    = p_rdata.pos;
                            state_next = S_LKV;
                        end else begin
                            status_next = ST_ABSENT;
                            found_next  = INT_MIN;
                            state_next  = S_TOP;
                        end
                    end
                endcase
            end
            S_POPRD: begin
                key_next   = h_rdata.key;
                pos_next   = '0;
                state_next = S_REM;
            end
            S_REM: begin
                // drop the key, move the last slot into the gap
                p_we      = 1'b1;
                p_waddr   = key_reg;
                p_wdata   = '0;
                fill_next = fill_dec;
                if (CNT_W'(pos_reg) < fill_dec) begin
                    h_re       = 1'b1;
                    h_raddr    = POS_W'(fill_dec);
                    state_next = S_LAST;
                end else begin
                    state_next = S_TOP;
                end
            end
            S_LAST: begin
                mov_next   = h_rdata;
                state_next = S_UP;
            end
            S_LKV: begin
                found_next = h_rdata.val;
                state_next = S_TOP;
            end
            S_UP: begin
                if (pos_reg == '0) begin
                    state_next = S_DNA;
                end else begin
                    h_re       = 1'b1;
                    h_raddr    = par_idx;
                    state_next = S_UPC;
                end
            end
            S_UPC: begin
                // parent smaller: it moves down into the hole
                if ($signed(h_rdata.val) < $signed(mov_reg.val)) begin
                    h_we       = 1'b1;
                    h_wdata    = h_rdata;
                    p_we       = 1'b1;
                    p_waddr    = h_rdata.key;
                    pos_next   = par_idx;
                    state_next = S_UP;
                end else begin
                    state_next = S_DNA;
                end
            end
            S_DNA: begin
                if (c1_idx >= CHD_W'(fill_reg)) begin
                    state_next = S_PLACE;
                end else begin
                    h_re       = 1'b1;
                    h_raddr    = c1_idx[POS_W-1:0];
                    state_next = S_DNB;
                end
            end
            S_DNB, S_DNC: begin
                if (state_reg == S_DNB && c2_idx < CHD_W'(fill_reg)) begin
                    c1d_next   = h_rdata;
                    h_re       = 1'b1;
                    h_raddr    = c2_idx[POS_W-1:0];
                    state_next = S_DNC;
                end else if ($signed(mov_reg.val) < $signed(best.val)) begin
                    // larger child moves up into the hole
                    h_we       = 1'b1;
                    h_wdata    = best;
                    p_we       = 1'b1;
                    p_waddr    = best.key;
                    pos_next   = best_idx[POS_W-1:0];
                    state_next = S_DNA;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                h_we       = 1'b1;
                p_we       = 1'b1;
                state_next = S_TOP;
            end
            S_TOP: begin
                // read the root, hold it until the result register frees
                if (!topr_reg) begin
                    h_re      = 1'b1;
                    topr_next = 1'b1;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end else begin
                    topr_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_tv_next     = m_tv_reg;
        m_tk_next     = m_tk_reg;
        m_tval_next   = m_tval_reg;
        m_cnt_next    = m_cnt_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == S_TOP && topr_reg && out_free) begin
            m_valid_next  = 1'b1;
            m_status_next = status_reg;
            m_found_next  = found_reg;
            m_tv_next     = (fill_reg != '0);
            m_tk_next     = (fill_reg != '0) ? h_rdata.key : '0;
            m_tval_next   = (fill_reg != '0) ? h_rdata.val : '0;
            m_cnt_next    = fill_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            fill_reg    <= '0;
            topr_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            fill_reg    <= fill_next;
            topr_reg    <= topr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        mov_reg      <= mov_next;
        c1d_reg      <= c1d_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_tv_reg     <= m_tv_next;
        m_tk_reg     <= m_tk_next;
        m_tval_reg   <= m_tval_next;
        m_cnt_reg    <= m_cnt_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_found_reg;
    assign m_top_valid   = m_tv_reg;
    assign m_top_key     = m_tk_reg;
    assign m_top_value   = m_tval_reg;
    assign m_entry_count = m_cnt_reg;

endmodule

/* sv/imh_checker.sv */
// Port-level checker for the indexed max-heap, bound to the top level.
`include "indexed_max_heap_assert.svh"

module imh_checker
    import imh_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [1:0]            s_command,
    input logic [KEY_W-1:0]      s_key,
    input logic [VALUE_BITS-1:0] s_value,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [1:0]            m_status,
    input logic [VALUE_BITS-1:0] m_found_value,
    input logic                  m_top_valid,
    input logic [KEY_W-1:0]      m_top_key,
    input logic [VALUE_BITS-1:0] m_top_value,
    input logic [CNT_W-1:0]      m_entry_count
);

    logic [2+KEY_W+VALUE_BITS-1:0]                     s_word;
    logic [2+VALUE_BITS+1+KEY_W+VALUE_BITS+CNT_W-1:0] m_word;
    logic                                              cnt_ok;
    logic                                              zero_ok;

    assign s_word  = {s_command, s_key, s_value};
    assign m_word  = {m_status, m_found_value, m_top_valid, m_top_key,
                      m_top_value, m_entry_count};
    assign cnt_ok  = (m_top_valid == (m_entry_count != '0)) &&
                     (m_entry_count <= CNT_W'(HEAP_DEPTH));
    assign zero_ok = (m_top_key == '0) && (m_top_value == '0);

    // a stalled result word stays offered and unchanged
    `IMH_ASSERT(a_m_hold, m_valid && !m_ready |=> m_valid && $stable(m_word), "result word changed")

    // a waiting command word stays offered and unchanged
    `IMH_ASSERT(a_s_hold, s_valid && !s_ready |=> s_valid && $stable(s_word), "command word changed")

    // root flag agrees with the entry count, which stays within the heap depth
    `IMH_ASSERT(a_top_cnt, m_valid |-> cnt_ok, "top_valid and entry_count disagree")

    // empty heap reports a zero pair
    `IMH_ASSERT(a_top_zero, m_valid && !m_top_valid |-> zero_ok, "empty heap reports a pair")

    // no input accepted while reset is held
    `IMH_ASSERT_ALWAYS(a_rst_ready, !aresetn |=> !s_ready, "ready high straight after reset")

endmodule

bind indexed_max_heap imh_checker u_imh_checker (.*);
